>>> hdl/aabbpo_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aabbpo_pkg - shared types, constants and functions
// Box record layout, command codes, sizing defaults and the overlap test
// used by the box pair overlap finder.
// ----------------------------------------------------------------------------
package aabbpo_pkg;

  // Default number of box slots per frame
  localparam int MAX_BOXES_DEF = 8;
  // Depth of the job queue between front and back
  localparam int JOB_FIFO_DEPTH_DEF = 2;
  // Most results reported by one evaluation
  localparam int RESULT_LIMIT = 28;

  // Command codes on in_func
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_EVAL = 1'b1;

  // Field widths
  localparam int COORD_W = 16;
  localparam int SIZE_W  = 15;
  localparam int OUT_IDX_W = 3;
  // Coordinate plus size needs one extra bit to stay exact; the sum keeps two
  localparam int SUM_W = COORD_W + 2;

  // Stored box geometry
  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [SIZE_W-1:0]         w;
    logic [SIZE_W-1:0]         h;
  } box_t;

  localparam int BOX_W = $bits(box_t);

  // Back to front: evaluation finished, bank free again
  typedef struct packed {
    logic done;
    logic bank;
  } back_status_t;

  // Inclusive-edge overlap test of two boxes
  function automatic logic boxes_touch(input box_t a, input box_t b);
    logic signed [SUM_W-1:0] ax, ay, bx, by;
    logic signed [SUM_W-1:0] ax2, ay2, bx2, by2;
    ax  = SUM_W'(a.x);
    ay  = SUM_W'(a.y);
    bx  = SUM_W'(b.x);
    by  = SUM_W'(b.y);
    ax2 = ax + $signed({3'b000, a.w});
    ay2 = ay + $signed({3'b000, a.h});
    bx2 = bx + $signed({3'b000, b.w});
    by2 = by + $signed({3'b000, b.h});
    return !((ay2 < by) || (ax2 < bx) || (ay > by2) || (ax > bx2));
  endfunction

endpackage

>>> hdl/aabbpo_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aabbpo_ram - generic RAM
// One write port, two read ports, read data registered.
// ----------------------------------------------------------------------------
module aabbpo_ram #(
  parameter int WIDTH = aabbpo_pkg::BOX_W,
  parameter int DEPTH = 2 * aabbpo_pkg::MAX_BOXES_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read ports
  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

>>> hdl/aabbpo_job_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aabbpo_job_fifo - evaluation job queue
// Short show-ahead queue carrying evaluation jobs from front to back.
// ----------------------------------------------------------------------------
module aabbpo_job_fifo #(
  parameter int WIDTH = 16,
  parameter int DEPTH = aabbpo_pkg::JOB_FIFO_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [NW-1:0]    fill_r,   fill_nxt;

  // Pointer wrap and fill level
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      fill_nxt = fill_r + NW'(1);
    end else if (pop && !push) begin
      fill_nxt = fill_r - NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  assign pop_data = slot_r[rd_ptr_r];
  assign empty    = (fill_r == '0);

endmodule

>>> hdl/aabbpo_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aabbpo_front - command front end
// Takes load and evaluate commands, writes boxes into the current bank,
// hands finished frames to the back as jobs and flips banks.
// ----------------------------------------------------------------------------
module aabbpo_front #(
  parameter int MAX_BOXES = aabbpo_pkg::MAX_BOXES_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  // Command channel
  input  logic                                     start,
  output logic                                     busy,
  input  logic                                     in_func,
  input  logic signed [aabbpo_pkg::COORD_W-1:0]    in_box_x,
  input  logic signed [aabbpo_pkg::COORD_W-1:0]    in_box_y,
  input  logic [aabbpo_pkg::SIZE_W-1:0]            in_box_width,
  input  logic [aabbpo_pkg::SIZE_W-1:0]            in_box_height,
  input  logic                                     in_box_active,
  // Box store write port
  output logic                                     ram_we,
  output logic [$clog2(MAX_BOXES):0]               ram_waddr,
  output logic [aabbpo_pkg::BOX_W-1:0]             ram_wdata,
  // Job queue push: {overflow, count, active mask, bank}
  output logic                                     job_push,
  output logic [$clog2(MAX_BOXES+1)+MAX_BOXES+1:0] job_data,
  // Completion from back
  input  aabbpo_pkg::back_status_t                 back_status
);

  localparam int IW = $clog2(MAX_BOXES);
  localparam int CW = $clog2(MAX_BOXES + 1);

  logic                 wbank_r;
  logic [1:0]           bank_busy_r;
  logic [CW-1:0]        count_r;
  logic                 overflow_r;
  logic [MAX_BOXES-1:0] mask_r;

  logic                 accept;
  logic                 room;
  aabbpo_pkg::box_t     box;

  assign accept = start && !busy;
  assign room   = (count_r < CW'(MAX_BOXES));
  // Stall only while the bank to be filled is still under evaluation
  assign busy   = bank_busy_r[wbank_r];

  // Box record for the store
  always_comb begin
    box.x = in_box_x;
    box.y = in_box_y;
    box.w = in_box_width;
    box.h = in_box_height;
  end

  assign ram_we    = accept && (in_func == aabbpo_pkg::FUNC_LOAD) && room;
  assign ram_waddr = {wbank_r, count_r[IW-1:0]};
  assign ram_wdata = box;

  assign job_push = accept && (in_func == aabbpo_pkg::FUNC_EVAL);
  assign job_data = {overflow_r, count_r, mask_r, wbank_r};

  // Frame bookkeeping and bank ownership
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wbank_r     <= 1'b0;
      bank_busy_r <= '0;
      count_r     <= '0;
      overflow_r  <= 1'b0;
      mask_r      <= '0;
    end else begin
      if (back_status.done) begin
        bank_busy_r[back_status.bank] <= 1'b0;
      end
      if (accept) begin
        if (in_func == aabbpo_pkg::FUNC_LOAD) begin
          if (room) begin
            mask_r[count_r[IW-1:0]] <= in_box_active;
            count_r                 <= count_r + CW'(1);
          end else begin
            overflow_r <= 1'b1;
          end
        end else begin
          bank_busy_r[wbank_r] <= 1'b1;
          wbank_r              <= ~wbank_r;
          count_r              <= '0;
          overflow_r           <= 1'b0;
          mask_r               <= '0;
        end
      end
    end
  end

endmodule

>>> hdl/aabbpo_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aabbpo_back - pair walker and result sequencer
// Walks every pair of a frame's slots, one pair a cycle through the box
// store and emits touching active pairs (last marked) or one empty result.
// ----------------------------------------------------------------------------
module aabbpo_back #(
  parameter int MAX_BOXES = aabbpo_pkg::MAX_BOXES_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  // Job queue
  input  logic                                     job_empty,
  input  logic [$clog2(MAX_BOXES+1)+MAX_BOXES+1:0] job_data,
  output logic                                     job_pop,
  // Box store read ports
  output logic [$clog2(MAX_BOXES):0]               ram_raddr_a,
  input  logic [aabbpo_pkg::BOX_W-1:0]             ram_rdata_a,
  output logic [$clog2(MAX_BOXES):0]               ram_raddr_b,
  input  logic [aabbpo_pkg::BOX_W-1:0]             ram_rdata_b,
  // Completion to front
  output aabbpo_pkg::back_status_t                 back_status,
  // Result channel
  output logic                                     out_valid,
  output logic [aabbpo_pkg::OUT_IDX_W-1:0]         out_first_index,
  output logic [aabbpo_pkg::OUT_IDX_W-1:0]         out_second_index,
  output logic                                     out_pair_valid,
  output logic                                     out_dropped_loads,
  output logic                                     out_last
);

  localparam int IW = $clog2(MAX_BOXES);
  localparam int CW = $clog2(MAX_BOXES + 1);
  localparam int FW = $clog2(aabbpo_pkg::RESULT_LIMIT + 1);
  localparam int XW = aabbpo_pkg::OUT_IDX_W;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_WALK  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_FINAL = 2'd3;

  logic [1:0]           state_r;
  logic                 bank_r;
  logic [CW-1:0]        cnt_r;
  logic [MAX_BOXES-1:0] mask_r;
  logic                 ovf_r;
  logic [IW-1:0]        i_r, j_r;
  logic                 s1_valid_r;
  logic [IW-1:0]        s1_i_r, s1_j_r;
  logic [FW-1:0]        found_r;
  logic                 have_pend_r;
  logic [IW-1:0]        pend_i_r, pend_j_r;
  aabbpo_pkg::back_status_t status_r;

  logic                 out_valid_r;
  logic [XW-1:0]        out_first_r, out_second_r;
  logic                 out_pair_r, out_drop_r, out_last_r;

  logic                 job_ovf;
  logic [CW-1:0]        job_cnt;
  logic [MAX_BOXES-1:0] job_mask;
  logic                 job_bank;
  aabbpo_pkg::box_t     box_a, box_b;
  logic                 hit;
  logic                 last_pair;

  assign {job_ovf, job_cnt, job_mask, job_bank} = job_data;
  assign job_pop = (state_r == ST_IDLE) && !job_empty;

  // Both slots of the current pair read in parallel
  assign ram_raddr_a = {bank_r, i_r};
  assign ram_raddr_b = {bank_r, j_r};
  assign box_a = ram_rdata_a;
  assign box_b = ram_rdata_b;

  // Overlap check on the pair read last cycle
  assign hit = s1_valid_r && aabbpo_pkg::boxes_touch(box_a, box_b)
               && (found_r < FW'(aabbpo_pkg::RESULT_LIMIT));

  assign last_pair = (CW'(i_r) == cnt_r - CW'(2)) && (CW'(j_r) == cnt_r - CW'(1));

  // Control: sequencer, walker, pending result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      bank_r      <= 1'b0;
      cnt_r       <= '0;
      mask_r      <= '0;
      i_r         <= '0;
      j_r         <= '0;
      s1_valid_r  <= 1'b0;
      found_r     <= '0;
      have_pend_r <= 1'b0;
      status_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r   <= 1'b0;
      status_r.done <= 1'b0;
      s1_valid_r    <= (state_r == ST_WALK) && mask_r[i_r] && mask_r[j_r];

      // A new hit pushes the previous one out, not yet known to be last
      if (hit) begin
        out_valid_r <= have_pend_r;
        have_pend_r <= 1'b1;
        found_r     <= found_r + FW'(1);
      end

      unique case (state_r)
        ST_IDLE: begin
          if (job_pop) begin
            bank_r      <= job_bank;
            cnt_r       <= job_cnt;
            mask_r      <= job_mask;
            i_r         <= '0;
            j_r         <= IW'(1);
            found_r     <= '0;
            have_pend_r <= 1'b0;
            state_r     <= (job_cnt < CW'(2)) ? ST_FINAL : ST_WALK;
          end
        end
        ST_WALK: begin
          if (last_pair) begin
            state_r <= ST_DRAIN;
          end else if (CW'(j_r) == cnt_r - CW'(1)) begin
            i_r <= i_r + IW'(1);
            j_r <= i_r + IW'(2);
          end else begin
            j_r <= j_r + IW'(1);
          end
        end
        ST_DRAIN: begin
          state_r <= ST_FINAL;
        end
        ST_FINAL: begin
          out_valid_r     <= 1'b1;
          have_pend_r     <= 1'b0;
          status_r.done   <= 1'b1;
          status_r.bank   <= bank_r;
          state_r         <= ST_IDLE;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // Payload: pair pipeline, pending pair, result fields
  always_ff @(posedge clk) begin
    s1_i_r <= i_r;
    s1_j_r <= j_r;
    if (job_pop) begin
      ovf_r <= job_ovf;
    end
    if (hit) begin
      pend_i_r     <= s1_i_r;
      pend_j_r     <= s1_j_r;
      out_first_r  <= XW'(pend_i_r);
      out_second_r <= XW'(pend_j_r);
      out_pair_r   <= 1'b1;
      out_drop_r   <= ovf_r;
      out_last_r   <= 1'b0;
    end
    if (state_r == ST_FINAL) begin
      out_first_r  <= have_pend_r ? XW'(pend_i_r) : '0;
      out_second_r <= have_pend_r ? XW'(pend_j_r) : '0;
      out_pair_r   <= have_pend_r;
      out_drop_r   <= ovf_r;
      out_last_r   <= 1'b1;
    end
  end

  assign back_status       = status_r;
  assign out_valid         = out_valid_r;
  assign out_first_index   = out_first_r;
  assign out_second_index  = out_second_r;
  assign out_pair_valid    = out_pair_r;
  assign out_dropped_loads = out_drop_r;
  assign out_last          = out_last_r;

endmodule

>>> hdl/aabb_pair_overlap_finder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aabb_pair_overlap_finder - pairwise box overlap finder
// Usage: a transfer on the command channel takes place when start is high
// and busy is low. in_func = load stores one box (x, y, width, height,
// active) in the next slot of the frame; loads beyond MAX_BOXES are dropped
// and flagged. in_func = evaluate closes the frame and tests every pair of
// active boxes, inclusive edges, in load order.
// Results come out one per cycle of out_valid; each is a transfer at that
// edge and cannot be held off by the receiver. A run gives one result per
// touching pair (at most 28) with out_last on the final one, or a single
// empty result with out_last set.
// For N stored boxes an evaluation walks P = N*(N-1)/2 pairs, one per
// cycle from the box store, once the back end is done with the previous frame.
// The store has two banks: the next frame loads while the previous one is
// evaluated, and busy rises only when both banks are held; a bank is freed
// the cycle after its last result.
// Reset (rst_n low, synchronous) empties both banks and the job queue.
// ----------------------------------------------------------------------------
module aabb_pair_overlap_finder #(
  parameter int MAX_BOXES      = aabbpo_pkg::MAX_BOXES_DEF,
  parameter int JOB_FIFO_DEPTH = aabbpo_pkg::JOB_FIFO_DEPTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic                                  in_func,
  input  logic signed [aabbpo_pkg::COORD_W-1:0] in_box_x,
  input  logic signed [aabbpo_pkg::COORD_W-1:0] in_box_y,
  input  logic [aabbpo_pkg::SIZE_W-1:0]         in_box_width,
  input  logic [aabbpo_pkg::SIZE_W-1:0]         in_box_height,
  input  logic                                  in_box_active,
  output logic                                  out_valid,
  output logic [aabbpo_pkg::OUT_IDX_W-1:0]      out_first_index,
  output logic [aabbpo_pkg::OUT_IDX_W-1:0]      out_second_index,
  output logic                                  out_pair_valid,
  output logic                                  out_dropped_loads,
  output logic                                  out_last
);

  localparam int IW        = $clog2(MAX_BOXES);
  localparam int CW        = $clog2(MAX_BOXES + 1);
  localparam int JOB_W     = CW + MAX_BOXES + 2;
  localparam int RAM_DEPTH = 2 * (2 ** IW);

  logic                            ram_we;
  logic [IW:0]                     ram_waddr;
  logic [aabbpo_pkg::BOX_W-1:0]    ram_wdata;
  logic [IW:0]                     ram_raddr_a, ram_raddr_b;
  logic [aabbpo_pkg::BOX_W-1:0]    ram_rdata_a, ram_rdata_b;
  logic                            job_push, job_pop, job_empty;
  logic [JOB_W-1:0]                job_in, job_out;
  aabbpo_pkg::back_status_t        back_status;

  // Command front end
  aabbpo_front #(
    .MAX_BOXES (MAX_BOXES)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_func       (in_func),
    .in_box_x      (in_box_x),
    .in_box_y      (in_box_y),
    .in_box_width  (in_box_width),
    .in_box_height (in_box_height),
    .in_box_active (in_box_active),
    .ram_we        (ram_we),
    .ram_waddr     (ram_waddr),
    .ram_wdata     (ram_wdata),
    .job_push      (job_push),
    .job_data      (job_in),
    .back_status   (back_status)
  );

  // Two-bank box store
  aabbpo_ram #(
    .WIDTH (aabbpo_pkg::BOX_W),
    .DEPTH (RAM_DEPTH)
  ) u_store (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (ram_raddr_a),
    .rdata_a (ram_rdata_a),
    .raddr_b (ram_raddr_b),
    .rdata_b (ram_rdata_b)
  );

  // Job queue between front and back
  aabbpo_job_fifo #(
    .WIDTH (JOB_W),
    .DEPTH (JOB_FIFO_DEPTH)
  ) u_jobs (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (job_push),
    .push_data (job_in),
    .pop       (job_pop),
    .pop_data  (job_out),
    .empty     (job_empty)
  );

  // Pair walker and result sequencer
  aabbpo_back #(
    .MAX_BOXES (MAX_BOXES)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .job_empty         (job_empty),
    .job_data          (job_out),
    .job_pop           (job_pop),
    .ram_raddr_a       (ram_raddr_a),
    .ram_rdata_a       (ram_rdata_a),
    .ram_raddr_b       (ram_raddr_b),
    .ram_rdata_b       (ram_rdata_b),
    .back_status       (back_status),
    .out_valid         (out_valid),
    .out_first_index   (out_first_index),
    .out_second_index  (out_second_index),
    .out_pair_valid    (out_pair_valid),
    .out_dropped_loads (out_dropped_loads),
    .out_last          (out_last)
  );

endmodule

>>> bench/tb_aabb_pair_overlap_finder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_aabb_pair_overlap_finder - self-checking bench for the box pair finder
// Loads frames of boxes, closes each with an evaluate command and checks
// every reported pair against an in-bench predictor. Covers coordinate and
// size extremes, touching edges, inactive boxes, store overflow and empty
// runs, then a long randomised part with random sender gaps.
// ----------------------------------------------------------------------------
module tb_aabb_pair_overlap_finder;

  localparam int   SLOTS        = aabbpo_pkg::MAX_BOXES_DEF;
  localparam int   COORD_W      = aabbpo_pkg::COORD_W;
  localparam int   SIZE_W       = aabbpo_pkg::SIZE_W;
  localparam int   OUT_IDX_W    = aabbpo_pkg::OUT_IDX_W;
  localparam int   RESULT_LIMIT = aabbpo_pkg::RESULT_LIMIT;
  localparam logic FUNC_LOAD    = aabbpo_pkg::FUNC_LOAD;
  localparam logic FUNC_EVAL    = aabbpo_pkg::FUNC_EVAL;
  localparam int   ITEM_TARGET  = 360;
  localparam int   STALL_LIMIT  = 2000;
  localparam int   REPORT_MAX   = 10;

  // One command as driven on the input channel
  typedef struct packed {
    logic                      func;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [SIZE_W-1:0]         w;
    logic [SIZE_W-1:0]         h;
    logic                      active;
  } box_cmd_t;

  // One reported pair
  typedef struct packed {
    logic [OUT_IDX_W-1:0] first_idx;
    logic [OUT_IDX_W-1:0] second_idx;
    logic                 pair_valid;
    logic                 dropped;
    logic                 last;
  } pair_result_t;

  // --------------------------------------------------------------------------
  // Scoreboard: tracks the frame being loaded and the pairs still owed
  // --------------------------------------------------------------------------
  class overlap_scoreboard;
    box_cmd_t     frame_boxes[SLOTS];
    int unsigned  filled;
    bit           overflowed;
    pair_result_t pending[$];
    int           mismatches;
    int           frames;
    int           pairs_owed;
    int           empty_runs;
    int           loads_kept;
    int           loads_dropped;

    function new();
      filled     = 0;
      overflowed = 1'b0;
    endfunction

    // Inclusive-edge overlap, exact in 32-bit arithmetic
    function bit spans_meet(box_cmd_t a, box_cmd_t b);
      int ax, ay, aw, ah, bx, by, bw, bh;
      ax = $signed(a.x);
      ay = $signed(a.y);
      bx = $signed(b.x);
      by = $signed(b.y);
      aw = a.w;
      ah = a.h;
      bw = b.w;
      bh = b.h;
      return !((ay + ah < by) || (ax + aw < bx) || (ay > by + bh) || (ax > bx + bw));
    endfunction

    // Accepted command: store a box, or work out the pairs of the frame
    function void note_command(box_cmd_t c);
      pair_result_t r;
      int found;
      if (c.func == FUNC_LOAD) begin
        if (filled < SLOTS) begin
          frame_boxes[filled] = c;
          filled++;
          loads_kept++;
        end else begin
          overflowed = 1'b1;
          loads_dropped++;
        end
        return;
      end
      found = 0;
      for (int i = 0; i < filled; i++) begin
        if (!frame_boxes[i].active) continue;
        for (int j = i + 1; j < filled; j++) begin
          if (!frame_boxes[j].active || found >= RESULT_LIMIT) continue;
          if (spans_meet(frame_boxes[i], frame_boxes[j])) begin
            r.first_idx  = OUT_IDX_W'(i);
            r.second_idx = OUT_IDX_W'(j);
            r.pair_valid = 1'b1;
            r.dropped    = overflowed;
            r.last       = 1'b0;
            pending.insert(pending.size(), r);
            found++;
          end
        end
      end
      if (found == 0) begin
        r = '0;
        r.dropped = overflowed;
        r.last    = 1'b1;
        pending.insert(pending.size(), r);
        empty_runs++;
      end else begin
        pending[pending.size() - 1].last = 1'b1;
        pairs_owed += found;
      end
      frames++;
      filled     = 0;
      overflowed = 1'b0;
    endfunction

    // Accepted result: compare with the oldest owed pair
    function void check_result(pair_result_t got);
      pair_result_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("ERROR: unexpected result first=%0d second=%0d valid=%0b drop=%0b last=%0b",
                   got.first_idx, got.second_idx, got.pair_valid, got.dropped, got.last);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= REPORT_MAX) begin
          $display("ERROR: result mismatch exp first=%0d second=%0d valid=%0b drop=%0b last=%0b",
                   want.first_idx, want.second_idx, want.pair_valid, want.dropped,
                   want.last);
          $display("       got first=%0d second=%0d valid=%0b drop=%0b last=%0b",
                   got.first_idx, got.second_idx, got.pair_valid, got.dropped,
                   got.last);
        end
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and DUT
  // --------------------------------------------------------------------------
  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      start = 1'b0;
  logic                      busy;
  logic                      in_func = FUNC_LOAD;
  logic signed [COORD_W-1:0] in_box_x = '0;
  logic signed [COORD_W-1:0] in_box_y = '0;
  logic [SIZE_W-1:0]         in_box_width = '0;
  logic [SIZE_W-1:0]         in_box_height = '0;
  logic                      in_box_active = 1'b0;
  logic                      out_valid;
  logic [OUT_IDX_W-1:0]      out_first_index;
  logic [OUT_IDX_W-1:0]      out_second_index;
  logic                      out_pair_valid;
  logic                      out_dropped_loads;
  logic                      out_last;

  overlap_scoreboard sb;
  int  items_sent = 0;
  bit  quiet_stretch = 1'b0;
  int  idle_cycles = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  aabb_pair_overlap_finder DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_func           (in_func),
    .in_box_x          (in_box_x),
    .in_box_y          (in_box_y),
    .in_box_width      (in_box_width),
    .in_box_height     (in_box_height),
    .in_box_active     (in_box_active),
    .out_valid         (out_valid),
    .out_first_index   (out_first_index),
    .out_second_index  (out_second_index),
    .out_pair_valid    (out_pair_valid),
    .out_dropped_loads (out_dropped_loads),
    .out_last          (out_last)
  );

  // Result monitor: every strobed cycle is a transfer
  always @(posedge clk) begin
    if (rst_n && out_valid)
      sb.check_result({out_first_index, out_second_index, out_pair_valid,
                       out_dropped_loads, out_last});
  end

  // Watchdog: cycles in a row with no transfer on either side
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("ERROR: no transfer for %0d cycles", STALL_LIMIT);
        $display("status: fail");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Drive tasks
  // --------------------------------------------------------------------------
  // Present a command and hold it until the block takes it
  task automatic send_command(input box_cmd_t c);
    start         <= 1'b1;
    in_func       <= c.func;
    in_box_x      <= c.x;
    in_box_y      <= c.y;
    in_box_width  <= c.w;
    in_box_height <= c.h;
    in_box_active <= c.active;
    do @(posedge clk); while (busy);
    sb.note_command(c);
    items_sent++;
    // random sender gap, about a quarter of the cycles
    if (!quiet_stretch && $urandom_range(99) < 23) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 23);
    end
  endtask

  // Hold the sender off until every owed result has arrived
  task automatic wait_for_drain();
    if (sb.pending.size() != 0) begin
      start <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clk);
    end
  endtask

  task automatic load_box(input int x, input int y, input int w, input int h,
                          input bit act);
    box_cmd_t c;
    c.func   = FUNC_LOAD;
    c.x      = COORD_W'(x);
    c.y      = COORD_W'(y);
    c.w      = SIZE_W'(w);
    c.h      = SIZE_W'(h);
    c.active = act;
    send_command(c);
  endtask

  // Evaluate with junk in the unused fields
  task automatic evaluate();
    box_cmd_t c;
    c      = box_cmd_t'({$urandom, $urandom, $urandom});
    c.func = FUNC_EVAL;
    send_command(c);
  endtask

  // Directed frames: extremes, edge contact, inactive boxes, overflow
  task automatic directed_frames();
    // nothing loaded at all
    evaluate();
    // coordinate and size extremes, corner contact, inactive overlap
    load_box(-32768, -32768, 32767, 32767, 1'b1);
    load_box(-1, -1, 0, 0, 1'b1);
    load_box(32767, 32767, 32767, 32767, 1'b1);
    load_box(32767, 32767, 0, 0, 1'b0);
    evaluate();
    // every slot overlapping plus one dropped inactive load
    for (int k = 0; k < SLOTS; k++)
      load_box(100 + k, 200 - k, 10, 10, 1'b1);
    load_box(100, 200, 10, 10, 1'b0);
    evaluate();
    // touching edges versus a one pixel gap
    load_box(0, 0, 10, 10, 1'b1);
    load_box(10, 0, 10, 10, 1'b1);
    load_box(21, 0, 10, 10, 1'b1);
    load_box(0, 10, 10, 10, 1'b1);
    evaluate();
    // a lone active box gives the empty result
    load_box(5, 5, 3, 3, 1'b1);
    load_box(5, 5, 3, 3, 1'b0);
    evaluate();
  endtask

  // Random frame: mostly clustered boxes so pairs actually meet
  task automatic random_frame();
    int roll, loads, cx, cy;
    bit clustered;
    box_cmd_t c;
    roll = $urandom_range(99);
    if (roll < 8)       loads = $urandom_range(0, 1);
    else if (roll < 82) loads = $urandom_range(2, SLOTS);
    else                loads = $urandom_range(SLOTS + 1, SLOTS + 3);
    clustered = ($urandom_range(99) < 75);
    cx = int'($urandom_range(64000)) - 32000;
    cy = int'($urandom_range(64000)) - 32000;
    for (int k = 0; k < loads; k++) begin
      c = box_cmd_t'({$urandom, $urandom, $urandom});
      c.func = FUNC_LOAD;
      if (clustered && $urandom_range(7) != 0) begin
        c.x = COORD_W'(cx + int'($urandom_range(80)) - 40);
        c.y = COORD_W'(cy + int'($urandom_range(80)) - 40);
        c.w = SIZE_W'($urandom_range(48));
        c.h = SIZE_W'($urandom_range(48));
      end
      c.active = ($urandom_range(99) < 85);
      send_command(c);
    end
    // occasionally let the back end empty before closing the frame
    if ($urandom_range(99) < 5) wait_for_drain();
    evaluate();
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    sb = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    directed_frames();
    wait_for_drain();
    while (items_sent < ITEM_TARGET) begin
      quiet_stretch = (items_sent >= 150 && items_sent < 230);
      random_frame();
    end
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("Ran %0d commands: %0d frames, %0d pairs, %0d empty runs.",
             items_sent, sb.frames, sb.pairs_owed, sb.empty_runs);
    $display("Boxes stored %0d, dropped on full store %0d, mismatches %0d.",
             sb.loads_kept, sb.loads_dropped, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
